>>> hdl/ipsg_pkg.sv
`default_nettype none

package ipsg_pkg;

  // Power stages
  localparam logic [1:0] STAGE_FULL    = 2'd0;
  localparam logic [1:0] STAGE_REDUCED = 2'd1;
  localparam logic [1:0] STAGE_LIGHT   = 2'd2;
  localparam logic [1:0] STAGE_DEEP    = 2'd3;

  // Request kinds
  localparam logic KIND_BOOT = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 32;
  localparam logic [CfgIndexW-1:0] CFG_REDUCED_AFTER = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_LIGHT_AFTER   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_DEEP_AFTER    = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_RECONNECT     = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_MIN_WAIT      = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_MAX_WAIT      = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_FULL_WAIT     = 3'd6;
  localparam logic [CfgIndexW-1:0] CFG_NAP_WAIT      = 3'd7;

  // Configuration reset values
  localparam logic [31:0] RST_REDUCED_AFTER = 32'd1000;
  localparam logic [31:0] RST_LIGHT_AFTER   = 32'd30000;
  localparam logic [31:0] RST_DEEP_AFTER    = 32'd300000;
  localparam logic [31:0] RST_RECONNECT     = 32'd10000;
  localparam logic [15:0] RST_MIN_WAIT      = 16'd5;
  localparam logic [15:0] RST_MAX_WAIT      = 16'd50;
  localparam logic [15:0] RST_FULL_WAIT     = 16'd5;
  localparam logic [15:0] RST_NAP_WAIT      = 16'd500;

  // Ramp product and divider sizing
  localparam int ProdW   = 48;
  localparam int DivCntW = $clog2(ProdW);

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic        woke_from_timer;
    logic        wifi_connected;
    logic        bt_connected;
    logic        engine_on;
    logic        ignition_on;
    logic        ignition_external;
    logic        active_after_sleep;
  } in_t;

  typedef struct packed {
    logic [1:0]  stage;
    logic        stage_entered;
    logic [15:0] wait_ms;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic classify;
    logic mul;
    logic div_start;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ramp;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

>>> hdl/idle_power_stage_governor.sv
`default_nettype none

// Channel   | Handshake                  | Payload
// ----------+----------------------------+----------------------------------
// request   | item_valid / item_stall    | item   (in_t: kind, now_ms, flags)
// result    | result_valid / result_stall| result (out_t: stage, entered, wait)
// config    | cfg_we                     | cfg_index, cfg_data
//
// One request at a time. Boot, active and non-ramp idle requests go from
// acceptance through eval, classify and multiply to commit; a request that lands
// in the reduced stage also runs the bit-per-cycle 48-bit ramp divider.
// rst is synchronous: configuration returns to its defaults, stage to full.
// A stalled result sits in the output register; the next request is taken
// meanwhile and waits before commit until that register frees up.

module idle_power_stage_governor
  import ipsg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire in_t                  item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output out_t                      result,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t st;

  // Sequencer: walks each request through eval, classify, ramp and commit
  ipsg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .cmd          (cmd)
  );

  // Datapath: configuration, idle timing, thresholds, ramp multiply/divide
  ipsg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .st        (st),
    .result    (result)
  );

`ifndef SYNTHESIS
  // an accepted request must start evaluation on the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> cmd.eval)
    else $error("accepted request did not advance to eval");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || !result_stall))
    else $error("commit over a pending result");

  // a commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("commit without result valid");

  // no new request while one is being committed
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> item_stall)
    else $error("request accepted during commit");
`endif

endmodule

`default_nettype wire

>>> hdl/ipsg_div.sv
`default_nettype none

module ipsg_div
  import ipsg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ProdW-1:0] dividend,
  input  wire logic [31:0]      divisor,
  output logic                  done,
  output logic [ProdW-1:0]      quotient
);

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [31:0]        rem;
  logic [ProdW-1:0]   dq;
  logic [32:0]        rem_sh;
  logic [32:0]        rem_sub;
  logic               ge;

  // One restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh  = {rem, dq[ProdW-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    ge      = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DivCntW'(ProdW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DivCntW'(ProdW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
      dq  <= {dq[ProdW-2:0], ge};
    end
  end

  assign quotient = dq;

endmodule

`default_nettype wire

>>> hdl/ipsg_dp.sv
`default_nettype none

module ipsg_dp
  import ipsg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  input  wire in_t                  item,
  input  wire cmd_t                 cmd,
  output status_t                   st,
  output out_t                      result
);

  // Configuration
  logic [31:0] reduced_after;
  logic [31:0] light_after;
  logic [31:0] deep_after;
  logic [31:0] reconnect;
  logic [15:0] min_wait;
  logic [15:0] max_wait;
  logic [15:0] full_wait;
  logic [15:0] nap_wait;

  // Governor state
  logic [31:0] idle_origin;
  logic        idle_valid;
  logic [1:0]  power_stage;

  // Working registers
  in_t              req;
  logic [31:0]      idle;
  logic [31:0]      boot_delta;
  logic [1:0]       cls_stage;
  logic [31:0]      pos;
  logic [31:0]      range;
  logic [15:0]      diff;
  logic [ProdW-1:0] prod;

  logic             active;
  logic             div_done;
  logic [ProdW-1:0] quotient;
  logic [16:0]      ramp_sum;
  logic [15:0]      ramp_wait;

  logic [31:0] idle_origin_next;
  logic        idle_valid_next;
  logic [1:0]  power_stage_next;
  logic        entered;
  logic [15:0] wait_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduced_after <= RST_REDUCED_AFTER;
      light_after   <= RST_LIGHT_AFTER;
      deep_after    <= RST_DEEP_AFTER;
      reconnect     <= RST_RECONNECT;
      min_wait      <= RST_MIN_WAIT;
      max_wait      <= RST_MAX_WAIT;
      full_wait     <= RST_FULL_WAIT;
      nap_wait      <= RST_NAP_WAIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REDUCED_AFTER: reduced_after <= cfg_data[31:0];
        CFG_LIGHT_AFTER:   light_after   <= cfg_data[31:0];
        CFG_DEEP_AFTER:    deep_after    <= cfg_data[31:0];
        CFG_RECONNECT:     reconnect     <= cfg_data[31:0];
        CFG_MIN_WAIT:      min_wait      <= cfg_data[15:0];
        CFG_MAX_WAIT:      max_wait      <= cfg_data[15:0];
        CFG_FULL_WAIT:     full_wait     <= cfg_data[15:0];
        CFG_NAP_WAIT:      nap_wait      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign active = req.wifi_connected | req.bt_connected | req.engine_on |
                  (req.ignition_on & req.ignition_external);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= item;
    end
    if (cmd.eval) begin
      idle       <= req.now_ms - (idle_valid ? idle_origin : req.now_ms);
      boot_delta <= deep_after - reconnect;
    end
    if (cmd.classify) begin
      if (idle < reduced_after) begin
        cls_stage <= STAGE_FULL;
      end else if (idle < light_after) begin
        cls_stage <= STAGE_REDUCED;
      end else if (idle < deep_after) begin
        cls_stage <= STAGE_LIGHT;
      end else begin
        cls_stage <= STAGE_DEEP;
      end
      pos   <= idle - reduced_after;
      range <= light_after - reduced_after;
      diff  <= (max_wait > min_wait) ? (max_wait - min_wait) : 16'd0;
    end
    if (cmd.mul) begin
      prod <= ProdW'(diff) * ProdW'(pos);
    end
  end

  ipsg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (range),
    .done     (div_done),
    .quotient (quotient)
  );

  assign st.ramp     = (req.kind == KIND_TICK) && !active && (cls_stage == STAGE_REDUCED);
  assign st.div_done = div_done;

  // Ramp end: add the start wait, cap at the top of the ramp
  always_comb begin
    ramp_sum = {1'b0, min_wait} + {1'b0, quotient[15:0]};
    if ((|quotient[ProdW-1:16]) || (ramp_sum > {1'b0, max_wait})) begin
      ramp_wait = max_wait;
    end else begin
      ramp_wait = ramp_sum[15:0];
    end
  end

  always_comb begin
    idle_origin_next = idle_origin;
    idle_valid_next  = idle_valid;
    power_stage_next = power_stage;
    entered          = 1'b0;
    wait_val         = 16'd0;
    if (req.kind == KIND_BOOT) begin
      power_stage_next = STAGE_FULL;
      entered          = 1'b1;
      idle_valid_next  = req.woke_from_timer;
      idle_origin_next = req.woke_from_timer ? (req.now_ms - boot_delta) : 32'd0;
    end else if (active) begin
      idle_valid_next  = 1'b0;
      power_stage_next = STAGE_FULL;
      entered          = (power_stage != STAGE_FULL);
      wait_val         = full_wait;
    end else begin
      idle_valid_next  = 1'b1;
      idle_origin_next = idle_valid ? idle_origin : req.now_ms;
      power_stage_next = cls_stage;
      entered          = (power_stage != cls_stage);
      case (cls_stage)
        STAGE_FULL:    wait_val = full_wait;
        STAGE_REDUCED: wait_val = ramp_wait;
        STAGE_LIGHT: begin
          wait_val = nap_wait;
          // activity on waking: drop back to full, always an entry
          if (req.active_after_sleep) begin
            idle_valid_next  = 1'b0;
            power_stage_next = STAGE_FULL;
            entered          = 1'b1;
          end
        end
        STAGE_DEEP:    wait_val = 16'd0;
        default:       wait_val = 16'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_origin <= '0;
      idle_valid  <= 1'b0;
      power_stage <= STAGE_FULL;
    end else if (cmd.commit) begin
      idle_origin <= idle_origin_next;
      idle_valid  <= idle_valid_next;
      power_stage <= power_stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.stage         <= power_stage_next;
      result.stage_entered <= entered;
      result.wait_ms       <= wait_val;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ipsg_ctrl.sv
`default_nettype none

module ipsg_ctrl
  import ipsg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  output logic         result_valid,
  input  wire logic    result_stall,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVAL   = 7'b0000010,
    S_CLASS  = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_DSTART = 7'b0010000,
    S_DWAIT  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;
  logic   out_free;

  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = st.ramp ? S_DSTART : S_DONE;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (st.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> dv/idle_power_stage_governor_tb.sv
`timescale 1ns / 1ps

import ipsg_pkg::*;

// Tracks the governor's stage and idle timing from every accepted request.
// Holds the expected responses in order and checks each one as it comes out.
class stage_scoreboard;
  logic [31:0] reduced_after, light_after, deep_after, reconnect_window;
  logic [15:0] min_wait, max_wait, full_wait, nap_wait;
  logic [31:0] idle_origin;
  bit          idle_valid;
  logic [1:0]  power_stage;
  out_t        expected_q[$];
  int          errors, requests, results;
  int          stage_hits[4];

  function void reset_state();
    reduced_after    = RST_REDUCED_AFTER;
    light_after      = RST_LIGHT_AFTER;
    deep_after       = RST_DEEP_AFTER;
    reconnect_window = RST_RECONNECT;
    min_wait         = RST_MIN_WAIT;
    max_wait         = RST_MAX_WAIT;
    full_wait        = RST_FULL_WAIT;
    nap_wait         = RST_NAP_WAIT;
    idle_origin      = '0;
    idle_valid       = 1'b0;
    power_stage      = STAGE_FULL;
  endfunction

  function void write_reg(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
    case (index)
      CFG_REDUCED_AFTER: reduced_after    = data;
      CFG_LIGHT_AFTER:   light_after      = data;
      CFG_DEEP_AFTER:    deep_after       = data;
      CFG_RECONNECT:     reconnect_window = data;
      CFG_MIN_WAIT:      min_wait         = data[15:0];
      CFG_MAX_WAIT:      max_wait         = data[15:0];
      CFG_FULL_WAIT:     full_wait        = data[15:0];
      CFG_NAP_WAIT:      nap_wait         = data[15:0];
      default: ;
    endcase
  endfunction

  function bit enter_stage(logic [1:0] s);
    if (power_stage == s) return 1'b0;
    power_stage = s;
    return 1'b1;
  endfunction

  // Linear ramp from min to max wait over the reduced window, capped at max.
  function logic [15:0] ramp_wait(logic [31:0] idle);
    logic [31:0] span, offset;
    logic [15:0] diff;
    logic [63:0] w;
    span   = light_after - reduced_after;
    offset = idle - reduced_after;
    diff   = (max_wait > min_wait) ? max_wait - min_wait : 16'd0;
    if (span == 0) return max_wait;
    w = 64'(min_wait) + (64'(diff) * 64'(offset)) / 64'(span);
    if (w > 64'(max_wait)) w = 64'(max_wait);
    return w[15:0];
  endfunction

  function void note_request(in_t r);
    out_t        e;
    bit          active;
    logic [31:0] idle;
    active = r.wifi_connected | r.bt_connected | r.engine_on |
             (r.ignition_on & r.ignition_external);
    e = '0;
    requests++;
    if (r.kind == KIND_BOOT) begin
      power_stage     = STAGE_FULL;
      e.stage_entered = 1'b1;
      if (r.woke_from_timer) begin
        idle_origin = r.now_ms - (deep_after - reconnect_window);
        idle_valid  = 1'b1;
      end else begin
        idle_origin = '0;
        idle_valid  = 1'b0;
      end
    end else if (active) begin
      idle_valid      = 1'b0;
      e.stage_entered = enter_stage(STAGE_FULL);
      e.wait_ms       = full_wait;
    end else begin
      if (!idle_valid) begin
        idle_origin = r.now_ms;
        idle_valid  = 1'b1;
      end
      idle = r.now_ms - idle_origin;
      if (idle < reduced_after) begin
        e.stage_entered = enter_stage(STAGE_FULL);
        e.wait_ms       = full_wait;
      end else if (idle < light_after) begin
        e.stage_entered = enter_stage(STAGE_REDUCED);
        e.wait_ms       = ramp_wait(idle);
      end else if (idle < deep_after) begin
        e.stage_entered = enter_stage(STAGE_LIGHT);
        e.wait_ms       = nap_wait;
        if (r.active_after_sleep) begin
          idle_valid      = 1'b0;
          e.stage_entered = e.stage_entered | enter_stage(STAGE_FULL);
        end
      end else begin
        e.stage_entered = enter_stage(STAGE_DEEP);
        e.wait_ms       = '0;
      end
    end
    e.stage = power_stage;
    expected_q.push_back(e);
  endfunction

  function void check_result(out_t got);
    out_t e;
    if (expected_q.size() == 0) begin
      $error("response with no request outstanding: stage %0d entered %0d wait %0d",
             got.stage, got.stage_entered, got.wait_ms);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    results++;
    stage_hits[e.stage]++;
    if (got.stage !== e.stage) begin
      $error("stage: expected %0d, got %0d", e.stage, got.stage);
      errors++;
    end
    if (got.stage_entered !== e.stage_entered) begin
      $error("stage_entered: expected %0d, got %0d", e.stage_entered, got.stage_entered);
      errors++;
    end
    if (got.wait_ms !== e.wait_ms) begin
      $error("wait_ms: expected %0d, got %0d", e.wait_ms, got.wait_ms);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module idle_power_stage_governor_tb;

  localparam int IdleLimit    = 2000;  // cycles with no handshake before giving up
  localparam int SettleCycles = 60;    // covers the ramp path
  localparam int LongHold     = 300;   // response-side back-pressure stretch
  localparam int PhaseItems   = 215;

  // Flag bits in request order: timer wake, wifi, bt, engine, ignition on,
  // ignition external, activity after light sleep.
  localparam logic [6:0] F_TIMER       = 7'b1000000;
  localparam logic [6:0] F_WIFI        = 7'b0100000;
  localparam logic [6:0] F_BT          = 7'b0010000;
  localparam logic [6:0] F_ENGINE      = 7'b0001000;
  localparam logic [6:0] F_IGN_ON      = 7'b0000100;
  localparam logic [6:0] F_IGN_EXT     = 7'b0000010;
  localparam logic [6:0] F_AFTER_SLEEP = 7'b0000001;

  localparam logic [CfgIndexW-1:0] CFG_ORDER[8] = '{
    CFG_REDUCED_AFTER, CFG_LIGHT_AFTER, CFG_DEEP_AFTER, CFG_RECONNECT,
    CFG_MIN_WAIT, CFG_MAX_WAIT, CFG_FULL_WAIT, CFG_NAP_WAIT
  };

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  in_t                  item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  out_t                 result;
  logic                 cfg_we       = 1'b0;
  logic [CfgIndexW-1:0] cfg_index    = CFG_REDUCED_AFTER;
  logic [CfgDataW-1:0]  cfg_data     = '0;

  stage_scoreboard sb = new();

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          long_hold_req  = 1'b0;
  int          idle_cycles    = 0;
  int          settings       = 0;
  logic [31:0] now_clock      = '0;  // running millisecond time for tick streams

  always #1 clk = ~clk;

  idle_power_stage_governor dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Response side: check on every accepted response, then pick next cycle's
  // stall. A long hold, once requested, is counted down here on its own.
  initial begin : response_side
    int hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      if (long_hold_req) begin
        hold_left     = LongHold;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL idle_power_stage_governor");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request and return on the edge that accepts it. Valid is left
  // high so a back-to-back request can follow in the same step; drop it
  // only while idling or before a pause.
  task automatic send_request(in_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= r;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic issue(logic kind, logic [31:0] now, logic [6:0] flags);
    send_request(in_t'({kind, now, flags}));
  endtask

  // Drop valid, wait for every outstanding response, then let the block go
  // quiet before anything touches the registers.
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all eight registers back to back. The 16-bit ones get random upper
  // bits on the bus, which the block must drop.
  task automatic write_config(logic [31:0] reduced, logic [31:0] light,
                              logic [31:0] deep, logic [31:0] reconnect,
                              logic [15:0] wmin, logic [15:0] wmax,
                              logic [15:0] wfull, logic [15:0] wlight);
    logic [CfgDataW-1:0] vals[8];
    logic [CfgDataW-1:0] d;
    vals[0] = reduced;
    vals[1] = light;
    vals[2] = deep;
    vals[3] = reconnect;
    vals[4] = {16'($urandom), wmin};
    vals[5] = {16'($urandom), wmax};
    vals[6] = {16'($urandom), wfull};
    vals[7] = {16'($urandom), wlight};
    for (int i = 0; i < 8; i++) begin
      d = vals[i];
      cfg_we    <= 1'b1;
      cfg_index <= CFG_ORDER[i];
      cfg_data  <= d;
      @(posedge clk);
      sb.write_reg(CFG_ORDER[i], d);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // One tick of a well-formed stream: advance time by a step scaled to the
  // current thresholds so idle time walks through every stage. A few ticks
  // are pure noise.
  function automatic in_t random_tick();
    logic [63:0] raw;
    logic [31:0] step;
    logic [6:0]  flags;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      raw = {$urandom, $urandom};
      return in_t'(raw[$bits(in_t)-1:0]);
    end
    if (pick < 45)      step = $urandom % (sb.light_after / 8 + 1);
    else if (pick < 70) step = $urandom % (sb.deep_after / 4 + 1);
    else if (pick < 80) step = '0;
    else if (pick < 90) step = $urandom_range(0, 3);
    else                step = $urandom;
    now_clock = now_clock + step;
    pick  = $urandom_range(0, 99);
    flags = '0;
    if (pick < 12)      flags = 7'($urandom);
    else if (pick < 20) flags = ($urandom_range(0, 1) ? F_IGN_ON : F_IGN_EXT) |
                                ($urandom_range(0, 1) ? F_TIMER : 7'b0);
    if ($urandom_range(0, 99) < 25) flags = flags | F_AFTER_SLEEP;
    return in_t'({KIND_TICK, now_clock, flags});
  endfunction

  // Bursts: a boot (often a timer wake) followed by a run of ticks.
  task automatic run_random(int count);
    in_t r;
    int  left, burst;
    left = count;
    while (left > 0) begin
      r = in_t'({KIND_BOOT, now_clock, 7'($urandom)});
      r.woke_from_timer = ($urandom_range(0, 99) < 35);
      send_request(r);
      left--;
      burst = $urandom_range(4, 40);
      while (burst > 0 && left > 0) begin
        send_request(random_tick());
        burst--;
        left--;
      end
    end
  endtask

  task automatic run_directed();
    // Walk the default thresholds: idle start at time zero, each boundary.
    issue(KIND_BOOT, 32'd0, '0);
    issue(KIND_TICK, 32'd0, '0);
    issue(KIND_TICK, 32'd999, '0);
    issue(KIND_TICK, 32'd1000, '0);
    issue(KIND_TICK, 32'd29999, '0);
    issue(KIND_TICK, 32'd30000, '0);
    // Activity on waking from light sleep returns to full.
    issue(KIND_TICK, 32'd30001, F_AFTER_SLEEP);
    issue(KIND_TICK, 32'd40000, '0);
    issue(KIND_TICK, 32'd340000, '0);
    issue(KIND_TICK, 32'd340001, '0);
    // Each activity source; ignition counts only when externally powered.
    issue(KIND_TICK, 32'd340002, F_WIFI);
    issue(KIND_TICK, 32'd340003, F_BT);
    issue(KIND_TICK, 32'd340004, F_ENGINE);
    issue(KIND_TICK, 32'd340005, F_IGN_ON);
    issue(KIND_TICK, 32'd341500, F_IGN_EXT);
    issue(KIND_TICK, 32'd341600, F_IGN_ON | F_IGN_EXT);
    // Timer wake backdates idle start; activity flags on a boot are ignored.
    issue(KIND_BOOT, 32'd5, 7'h7F);
    issue(KIND_TICK, 32'd5, '0);
    issue(KIND_TICK, 32'd10005, '0);
    // Time wrapping across zero.
    issue(KIND_BOOT, 32'hFFFF_FF00, '0);
    issue(KIND_TICK, 32'hFFFF_FF00, '0);
    issue(KIND_TICK, 32'h0000_0300, '0);
    issue(KIND_TICK, 32'hFFFF_FFFF, 7'h7F);
    settle();
    // Widest ramp product.
    write_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(KIND_BOOT, 32'd0, '0);
    issue(KIND_TICK, 32'd0, '0);
    issue(KIND_TICK, 32'hFFFF_FFFE, '0);
    settle();
    // Max wait below min wait.
    write_config(32'd100, 32'd2000, 32'd10000, 32'd3000,
                 16'hFFFF, 16'd0, 16'd0, 16'd0);
    issue(KIND_TICK, 32'd1000, '0);
    settle();
  endtask

  initial begin : stimulus
    logic [31:0] t_reduced, t_light, t_deep;
    sb.reset_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < 8; p++) begin
      // Rotate idling: none, request side, response side, both lightly.
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase

      case (p)
        0: write_config(RST_REDUCED_AFTER, RST_LIGHT_AFTER, RST_DEEP_AFTER, RST_RECONNECT,
                        RST_MIN_WAIT, RST_MAX_WAIT, RST_FULL_WAIT, RST_NAP_WAIT);
        1: write_config(32'd100, 32'd2000, 32'd10000, 32'd3000,
                        16'd2, 16'd40, 16'd1, 16'd250);
        2: write_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                        16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: write_config('0, '0, '0, '0, '0, '0, '0, '0);
        4: write_config(32'd50, 32'd800, 32'd5000, 32'd6000,
                        16'd1000, 16'd3, 16'd7, 16'hFFFF);
        5: write_config(32'd5000, 32'd1000, 32'd3000, 32'd200,
                        16'd10, 16'd90, 16'd3, 16'd40);
        6: begin
          t_reduced = $urandom_range(0, 5000);
          t_light   = t_reduced + $urandom_range(1, 50000);
          t_deep    = t_light + $urandom_range(0, 200000);
          write_config(t_reduced, t_light, t_deep, $urandom_range(0, t_deep),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        default: write_config($urandom, $urandom, $urandom, $urandom,
                              16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
      endcase

      if (p == 1) begin
        // Hold off responses for a long stretch while requests keep coming,
        // so the block backs up and stalls its input.
        run_random(PhaseItems / 2);
        long_hold_req = 1'b1;
        run_random(PhaseItems - PhaseItems / 2);
      end else if (p == 2) begin
        // Pause requests until every response is back, then resume.
        run_random(PhaseItems / 2);
        settle();
        run_random(PhaseItems - PhaseItems / 2);
      end else begin
        run_random(PhaseItems);
      end
      settle();
    end

    $display("%0d requests and %0d responses over %0d register settings",
             sb.requests, sb.results, settings);
    $display("responses by stage full/reduced/light/deep: %0d/%0d/%0d/%0d",
             sb.stage_hits[0], sb.stage_hits[1], sb.stage_hits[2], sb.stage_hits[3]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS idle_power_stage_governor");
    end else begin
      $display("FAIL idle_power_stage_governor");
    end
    $finish;
  end

endmodule
